/* hdl/ropt_pkg.sv */
package ropt_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;

   localparam int NODE_W     = 16;
   localparam int ADDR_W     = 64;
   localparam int RANK_W     = 16;
   localparam int MAC_W      = 48;
   localparam int STATUS_W   = 2;
   localparam int OWN_RANK_W = 17;

   localparam int REQ_DATA_W = 208;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 216;
   localparam int RSP_USER_W = 4;

   // item kinds
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // query answers
   localparam logic [STATUS_W-1:0] ST_EXISTS  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DIFFERS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;

   // one table entry, node id in the lowest bits (same layout as req_tdata)
   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [RANK_W-1:0] rank;
      logic [ADDR_W-1:0] addr_lo;
      logic [ADDR_W-1:0] addr_hi;
      logic [NODE_W-1:0] node;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [RSP_DATA_W-OWN_RANK_W-MAC_W-2*ADDR_W-NODE_W-1:0] pad;
      logic [OWN_RANK_W-1:0] own_rank;
      logic [MAC_W-1:0]      pref_mac;
      logic [ADDR_W-1:0]     pref_addr_lo;
      logic [ADDR_W-1:0]     pref_addr_hi;
      logic [NODE_W-1:0]     pref_node;
   } rsp_data_type;

   typedef struct packed {
      logic                pref_valid;
      logic                table_full;
      logic [STATUS_W-1:0] status;
   } rsp_user_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan_run;
      logic plan;
      logic move_run;
      logic write_new;
      logic rsp_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic move_done;
      logic is_query;
      logic drop;
   } dp_stat_type;

endpackage

/* hdl/ropt_ram.sv */
module ropt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/ropt_datapath.sv */
module ropt_datapath #(
   parameter int TABLE_ENTRIES = ropt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ropt_pkg::dp_cmd_type   cmd,
   output ropt_pkg::dp_stat_type  stat,
   input  logic                   req_cmd,
   input  ropt_pkg::entry_type    req_entry,
   output ropt_pkg::rsp_data_type rsp_data,
   output ropt_pkg::rsp_user_type rsp_user
);
   import ropt_pkg::*;

   localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNTW-1:0] NUM = CNTW'(TABLE_ENTRIES);
   localparam logic [CNTW-1:0] ONE = CNTW'(1);

   logic            cmd_ff, cmd_in;
   entry_type       item_ff, item_in;
   entry_type       head_ff, head_in;
   logic [CNTW-1:0] used_ff, used_in;
   // scan
   logic [CNTW-1:0] ptr_ff, ptr_in;
   logic            ev_valid_ff, ev_valid_in;
   logic [CNTW-1:0] ev_idx_ff, ev_idx_in;
   logic            found_ff, found_in;
   logic [CNTW-1:0] pos_ff, pos_in;
   logic [CNTW-1:0] ins_ff, ins_in;
   logic [STATUS_W-1:0] qst_ff, qst_in;
   logic            drop_ff, drop_in;
   // move
   logic            mv_right_ff, mv_right_in;
   logic [CNTW-1:0] mv_rd_ff, mv_rd_in;
   logic [CNTW-1:0] mv_left_ff, mv_left_in;
   logic            mv_pend_ff, mv_pend_in;
   logic [CNTW-1:0] mv_dst_ff, mv_dst_in;
   // result
   rsp_data_type    rsp_data_ff, rsp_data_in;
   rsp_user_type    rsp_user_ff, rsp_user_in;

   logic            rd_en, wr_en;
   logic [IDXW-1:0] rd_addr, wr_addr;
   entry_type       wr_data;
   logic [ENTRY_W-1:0] rd_data;
   entry_type       rd_ent;

   logic            hit, rank_lt, rank_le, drop_now, scan_more;
   logic [CNTW-1:0] p_eff;

   ropt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_ent  = entry_type'(rd_data);
   assign rank_lt = rd_ent.rank <  item_ff.rank;
   assign rank_le = rd_ent.rank <= item_ff.rank;
   assign hit     = ev_valid_ff && !found_ff &&
                    ((cmd_ff == CMD_QUERY) ?
                     (rd_ent.addr_hi == item_ff.addr_hi && rd_ent.addr_lo == item_ff.addr_lo) :
                     (rd_ent.node == item_ff.node));
   assign scan_more = ptr_ff < used_ff;
   assign drop_now  = (cmd_ff == CMD_UPDATE) && !found_ff && (used_ff == NUM);
   // an unmatched update goes in as if from one past the end
   assign p_eff     = found_ff ? pos_ff : used_ff;

   assign stat.scan_done = !scan_more && !ev_valid_ff;
   assign stat.move_done = (mv_left_ff == '0) && !mv_pend_ff;
   assign stat.is_query  = cmd_ff == CMD_QUERY;
   assign stat.drop      = drop_now;

   always_comb begin
      cmd_in      = cmd_ff;
      item_in     = item_ff;
      head_in     = head_ff;
      used_in     = used_ff;
      ptr_in      = ptr_ff;
      ev_valid_in = 1'b0;
      ev_idx_in   = ev_idx_ff;
      found_in    = found_ff;
      pos_in      = pos_ff;
      ins_in      = ins_ff;
      qst_in      = qst_ff;
      drop_in     = drop_ff;
      mv_right_in = mv_right_ff;
      mv_rd_in    = mv_rd_ff;
      mv_left_in  = mv_left_ff;
      mv_pend_in  = 1'b0;
      mv_dst_in   = mv_dst_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rd_en       = 1'b0;
      rd_addr     = ptr_ff[IDXW-1:0];
      wr_en       = 1'b0;
      wr_addr     = ins_ff[IDXW-1:0];
      wr_data     = item_ff;

      if (cmd.load) begin
         cmd_in   = req_cmd;
         item_in  = req_entry;
         ptr_in   = '0;
         found_in = 1'b0;
         pos_in   = '0;
         ins_in   = '0;
         qst_in   = ST_ABSENT;
      end

      // scan: one read issued a cycle, judged the cycle after
      if (cmd.scan_run) begin
         drop_in = drop_now;
         if (scan_more) begin
            rd_en       = 1'b1;
            rd_addr     = ptr_ff[IDXW-1:0];
            ptr_in      = ptr_ff + ONE;
            ev_valid_in = 1'b1;
            ev_idx_in   = ptr_ff;
         end
      end

      // insert point counts the others that stay ahead: before the match
      // equal ranks stay ahead, after it only smaller ones
      if (ev_valid_ff) begin
         if (hit) begin
            found_in = 1'b1;
            pos_in   = ev_idx_ff;
            qst_in   = (rd_ent.rank == item_ff.rank) ? ST_EXISTS : ST_DIFFERS;
         end else if (found_ff ? rank_lt : rank_le) begin
            ins_in = ins_ff + ONE;
         end
      end

      if (cmd.plan) begin
         if (ins_ff < p_eff) begin
            mv_right_in = 1'b1;
            mv_rd_in    = p_eff - ONE;
            mv_left_in  = p_eff - ins_ff;
         end else begin
            mv_right_in = 1'b0;
            mv_rd_in    = p_eff + ONE;
            mv_left_in  = ins_ff - p_eff;
         end
      end

      // move: write back last read while the next one is issued
      if (mv_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = mv_dst_ff[IDXW-1:0];
         wr_data = rd_ent;
      end
      if (cmd.move_run && mv_left_ff != '0) begin
         rd_en      = 1'b1;
         rd_addr    = mv_rd_ff[IDXW-1:0];
         mv_pend_in = 1'b1;
         mv_dst_in  = mv_right_ff ? mv_rd_ff + ONE : mv_rd_ff - ONE;
         mv_rd_in   = mv_right_ff ? mv_rd_ff - ONE : mv_rd_ff + ONE;
         mv_left_in = mv_left_ff - ONE;
      end

      if (cmd.write_new) begin
         wr_en   = 1'b1;
         wr_addr = ins_ff[IDXW-1:0];
         wr_data = item_ff;
         if (!found_ff) begin
            used_in = used_ff + ONE;
         end
      end

      // shadow of entry 0 for the preferred parent
      if (wr_en && wr_addr == '0) begin
         head_in = wr_data;
      end

      if (cmd.rsp_load) begin
         rsp_user_in.status     = (cmd_ff == CMD_QUERY) ? qst_ff : ST_EXISTS;
         rsp_user_in.table_full = drop_ff;
         rsp_user_in.pref_valid = used_ff != '0;
         rsp_data_in = '0;
         if (used_ff != '0) begin
            rsp_data_in.pref_node    = head_ff.node;
            rsp_data_in.pref_addr_hi = head_ff.addr_hi;
            rsp_data_in.pref_addr_lo = head_ff.addr_lo;
            rsp_data_in.pref_mac     = head_ff.mac;
            rsp_data_in.own_rank     = {1'b0, head_ff.rank} + OWN_RANK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         ev_valid_ff <= 1'b0;
         mv_pend_ff  <= 1'b0;
         mv_left_ff  <= '0;
      end else begin
         used_ff     <= used_in;
         ev_valid_ff <= ev_valid_in;
         mv_pend_ff  <= mv_pend_in;
         mv_left_ff  <= mv_left_in;
      end
      cmd_ff      <= cmd_in;
      item_ff     <= item_in;
      head_ff     <= head_in;
      ptr_ff      <= ptr_in;
      ev_idx_ff   <= ev_idx_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      ins_ff      <= ins_in;
      qst_ff      <= qst_in;
      drop_ff     <= drop_in;
      mv_right_ff <= mv_right_in;
      mv_rd_ff    <= mv_rd_in;
      mv_dst_ff   <= mv_dst_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_data = rsp_data_ff;
   assign rsp_user = rsp_user_ff;

`ifndef NO_ASSERTIONS
   a_used_bound : assert property (@(posedge clock) disable iff (reset)
      used_ff <= NUM)
      else $error("entry count beyond table size");

   a_used_step : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && used_ff != $past(used_ff)) |-> used_ff == $past(used_ff) + ONE)
      else $error("entry count moved by other than one");

   a_rw_apart : assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> rd_addr != wr_addr)
      else $error("shift read and write hit the same entry");
`endif

endmodule

/* hdl/ropt_ctrl.sv */
module ropt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output ropt_pkg::dp_cmd_type  cmd,
   input  ropt_pkg::dp_stat_type stat
);
   import ropt_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      PLAN,
      MOVE,
      WRITE,
      DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = SCAN;
            end
         end
         SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               state_in = (stat.is_query || stat.drop) ? DONE : PLAN;
            end
         end
         PLAN: begin
            cmd.plan = 1'b1;
            state_in = MOVE;
         end
         MOVE: begin
            cmd.move_run = 1'b1;
            if (stat.move_done) begin
               state_in = WRITE;
            end
         end
         WRITE: begin
            cmd.write_new = 1'b1;
            state_in      = DONE;
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = state_ff == IDLE;
   assign rsp_tvalid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_one_item : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while one is in work");

   a_slot_free : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

   a_cmd_excl : assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("datapath commands overlap");
`endif

endmodule

/* hdl/rank_ordered_parent_table_core.sv */
// Rank-ordered parent table.
// req channel: one item per handshake. req_tuser selects the kind (update or
// query); req_tdata carries node id, address halves, rank and MAC. An update
// overwrites the entry of its node id or appends one, keeping the table in
// ascending rank with ties in arrival order; a query looks up by address.
// rsp channel: exactly one result item per request item, in order, carrying
// the query answer, the table-full flag and the current preferred parent
// (first entry) with its rank plus one.
// Flow: one item at a time. The table lives in a single RAM with one read
// and one write port; each item walks the used entries at one a cycle, and an
// update then shifts the entries between its old and new place at one a
// cycle. req_tready rises with rsp_tvalid, so no new item is taken while
// one is in work.
// Reset clears the entry count, not the RAM contents; no RAM clearing pass,
// the table is empty at once. A stalled receiver holds the result in the
// output register; the next item is still taken and worked, and waits for
// the register to drain.
module rank_ordered_parent_table_core #(
   parameter int TABLE_ENTRIES = ropt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // node_id[15:0] addr_hi[79:16] addr_lo[143:80] rank[159:144] mac[207:160]
   input  logic [ropt_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd[0]
   input  logic [ropt_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pref_node[15:0] pref_addr_hi[79:16] pref_addr_lo[143:80]
   // pref_mac[191:144] own_rank[208:192] zero[215:209]
   output logic [ropt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0] table_full[2] pref_valid[3]
   output logic [ropt_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import ropt_pkg::*;

   dp_cmd_type   cmd;
   dp_stat_type  stat;
   entry_type    req_entry;
   rsp_data_type rsp_data;
   rsp_user_type rsp_user;

   // request payload lines up with the entry layout
   assign req_entry = entry_type'(req_tdata);

   ropt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   ropt_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_cmd   (req_tuser[0]),
      .req_entry (req_entry),
      .rsp_data  (rsp_data),
      .rsp_user  (rsp_user)
   );

   assign rsp_tdata = rsp_data;
   assign rsp_tuser = rsp_user;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import ropt_pkg::*;

   localparam int ENTRIES     = TABLE_ENTRIES_DEF;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_WAIT  = 60;
   localparam int HOLD_OFF    = 500;

   // one request item: kind plus the entry fields in req_tdata order
   typedef struct {
      logic      cmd;
      entry_type e;
   } parent_msg_type;

   // one result item as the block should send it
   typedef struct {
      rsp_user_type u;
      rsp_data_type d;
   } parent_answer_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // shadow parent table, kept in rank order exactly as the block should keep it
   entry_type         parent_tbl [ENTRIES];
   int                parent_count;
   parent_answer_type expected_answers [$];

   int                mismatch_count;
   int                cycle_count;

   // sender burst control
   bit                gaps_on;
   int                burst_left;

   // receiver stall control
   int                hold_cycles;
   int                stall_mode;
   int                mode_left;
   int                stall_phase;

   parent_answer_type want;
   rsp_user_type      got_u;
   rsp_data_type      got_d;

   rank_ordered_parent_table_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_answers.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Applies one item to the shadow table and returns the result it causes.
   // Update: overwrite by node id, else append, else flag full; then a stable
   // insertion sort by rank so a new entry lands after equal ranks.
   // Query: first entry in table order whose 128-bit address matches.
   function automatic parent_answer_type predict_parent_answer(parent_msg_type m);
      parent_answer_type a;
      entry_type         tmp;
      int                i;
      int                j;
      bit                hit;
      a.u = '0;
      a.d = '0;
      hit = 1'b0;
      if (m.cmd == CMD_UPDATE) begin
         for (i = 0; i < parent_count; i++) begin
            if (!hit && parent_tbl[i].node == m.e.node) begin
               parent_tbl[i] = m.e;
               hit = 1'b1;
            end
         end
         if (!hit) begin
            if (parent_count < ENTRIES) begin
               parent_tbl[parent_count] = m.e;
               parent_count++;
            end else begin
               a.u.table_full = 1'b1;
            end
         end
         for (i = 1; i < parent_count; i++) begin
            for (j = i; j > 0 && parent_tbl[j].rank < parent_tbl[j-1].rank; j--) begin
               tmp             = parent_tbl[j];
               parent_tbl[j]   = parent_tbl[j-1];
               parent_tbl[j-1] = tmp;
            end
         end
      end else begin
         a.u.status = ST_ABSENT;
         for (i = 0; i < parent_count; i++) begin
            if (!hit && parent_tbl[i].addr_hi == m.e.addr_hi &&
                parent_tbl[i].addr_lo == m.e.addr_lo) begin
               a.u.status = (parent_tbl[i].rank == m.e.rank) ? ST_EXISTS : ST_DIFFERS;
               hit = 1'b1;
            end
         end
      end
      // preferred parent is always the head of the table; all zero when empty
      if (parent_count > 0) begin
         a.u.pref_valid     = 1'b1;
         a.d.pref_node      = parent_tbl[0].node;
         a.d.pref_addr_hi   = parent_tbl[0].addr_hi;
         a.d.pref_addr_lo   = parent_tbl[0].addr_lo;
         a.d.pref_mac       = parent_tbl[0].mac;
         a.d.own_rank       = {1'b0, parent_tbl[0].rank} + 17'd1;
      end
      return a;
   endfunction

   // ---------------------------------------------------------------------
   // Item construction
   // ---------------------------------------------------------------------

   function automatic parent_msg_type make_msg(logic cmd, logic [NODE_W-1:0] node,
                                               logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] lo,
                                               logic [RANK_W-1:0] rank, logic [MAC_W-1:0] mac);
      parent_msg_type m;
      m.cmd       = cmd;
      m.e.node    = node;
      m.e.addr_hi = hi;
      m.e.addr_lo = lo;
      m.e.rank    = rank;
      m.e.mac     = mac;
      return m;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // ranks bunched low so ties are common, with the extremes well represented
   function automatic logic [RANK_W-1:0] random_rank();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5)       return RANK_W'($urandom_range(0, 7));
      else if (sel == 5) return '0;
      else if (sel == 6) return '1;
      else               return RANK_W'($urandom);
   endfunction

   // Mostly items aimed at live entries: updates to known node ids (which
   // reorder the table), queries on stored addresses with the stored rank or
   // another. The rest are fresh node ids (dropped once full) and misses.
   function automatic parent_msg_type random_msg();
      parent_msg_type m;
      entry_type      pick;
      entry_type      other;
      m = make_msg(($urandom_range(0, 9) < 6) ? CMD_UPDATE : CMD_QUERY,
                   NODE_W'($urandom), rand64(), rand64(), random_rank(), MAC_W'(rand64()));
      if (parent_count > 0) begin
         pick  = parent_tbl[$urandom_range(0, parent_count - 1)];
         other = parent_tbl[$urandom_range(0, parent_count - 1)];
         if (m.cmd == CMD_UPDATE) begin
            if ($urandom_range(0, 3) != 0)
               m.e.node = pick.node;
            // shared address under another node id
            if ($urandom_range(0, 3) == 0) begin
               m.e.addr_hi = other.addr_hi;
               m.e.addr_lo = other.addr_lo;
            end
         end else if ($urandom_range(0, 9) < 7) begin
            m.e.addr_hi = pick.addr_hi;
            m.e.addr_lo = pick.addr_lo;
            if ($urandom_range(0, 1) == 1)
               m.e.rank = pick.rank;
         end
      end
      return m;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: bursts of random length with random gaps; valid stays high
   // between back-to-back items. Prediction happens at acceptance.
   // ---------------------------------------------------------------------
   task automatic offer_item(parent_msg_type m);
      int gap;
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= m.e;
      req_tuser  <= m.cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_answers.insert(expected_answers.size(), predict_parent_answer(m));
   endtask

   // ---------------------------------------------------------------------
   // Receiver: own stall pattern, switching mode at random;
   // a hold-off request from the test overrides it for a counted stretch.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 300);
         end
         mode_left--;
         stall_phase++;
         case (stall_mode)
            0: rsp_tready <= 1'b1;                                // no stalls
            1: rsp_tready <= ($urandom_range(0, 99) >= 35);       // random
            2: rsp_tready <= ((stall_phase % 7) < 4);             // periodic
            default: rsp_tready <= ($urandom_range(0, 9) == 0);   // heavy
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Result checking: field by field against the oldest expectation
   // ---------------------------------------------------------------------
   task automatic check_field(string what, logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s at cycle %0d: expected %h, got %h",
                     what, cycle_count, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got_u = rsp_tuser;
         got_d = rsp_tdata;
         if (expected_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result item with nothing expected at cycle %0d: user %h data %h",
                        cycle_count, rsp_tuser, rsp_tdata);
         end else begin
            want = expected_answers.pop_front();
            check_field("status",       64'(want.u.status),     64'(got_u.status));
            check_field("table_full",   64'(want.u.table_full), 64'(got_u.table_full));
            check_field("pref_valid",   64'(want.u.pref_valid), 64'(got_u.pref_valid));
            check_field("pref_node",    64'(want.d.pref_node),  64'(got_d.pref_node));
            check_field("pref_addr_hi", want.d.pref_addr_hi,    got_d.pref_addr_hi);
            check_field("pref_addr_lo", want.d.pref_addr_lo,    got_d.pref_addr_lo);
            check_field("pref_mac",     64'(want.d.pref_mac),   64'(got_d.pref_mac));
            check_field("own_rank",     64'(want.d.own_rank),   64'(got_d.own_rank));
            check_field("tdata pad",    64'(want.d.pad),        64'(got_d.pad));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // query before any update: absent, no preferred parent, fields zero
   task automatic test_empty_table();
      offer_item(make_msg(CMD_QUERY, NODE_W'($urandom), rand64(), rand64(),
                          RANK_W'($urandom), MAC_W'(rand64())));
   endtask

   // all-ones entry gives own rank 0x10000; all-zeros entry then takes the head
   task automatic test_extreme_fields();
      offer_item(make_msg(CMD_UPDATE, '0, '1, '1, '1, '1));
      offer_item(make_msg(CMD_QUERY, '1, '1, '1, '1, '0));
      offer_item(make_msg(CMD_QUERY, '0, '1, '1, 16'h7FFF, '0));
      offer_item(make_msg(CMD_UPDATE, '1, '0, '0, '0, '0));
   endtask

   // equal ranks keep arrival order; overwrite in place; move up and to the tail
   task automatic test_rank_ties();
      offer_item(make_msg(CMD_UPDATE, 16'd5, 64'h5, 64'h50, 16'd100, 48'h5));
      offer_item(make_msg(CMD_UPDATE, 16'd6, 64'h6, 64'h60, 16'd100, 48'h6));
      offer_item(make_msg(CMD_UPDATE, 16'd7, 64'h7, 64'h70, 16'd100, 48'h7));
      offer_item(make_msg(CMD_UPDATE, 16'd5, 64'h5, 64'h55, 16'd100, 48'h55));
      offer_item(make_msg(CMD_UPDATE, 16'd6, 64'h6, 64'h60, 16'd50, 48'h66));
      offer_item(make_msg(CMD_UPDATE, '1, '0, '0, '1, '1));
   endtask

   // same address under node 7 and node 8: the query sees node 7 first
   task automatic test_duplicate_address();
      offer_item(make_msg(CMD_UPDATE, 16'd8, 64'h7, 64'h70, 16'd200, 48'h8));
      offer_item(make_msg(CMD_QUERY, '0, 64'h7, 64'h70, 16'd200, '0));
      offer_item(make_msg(CMD_QUERY, '0, 64'h7, 64'h70, 16'd100, '0));
   endtask

   // fill the table, then a new node id is dropped; a known one still moves
   task automatic test_full_table();
      int k;
      for (k = parent_count; k < ENTRIES; k++)
         offer_item(make_msg(CMD_UPDATE, NODE_W'(16'h100 + k), rand64(), rand64(),
                             random_rank(), MAC_W'(rand64())));
      offer_item(make_msg(CMD_UPDATE, 16'h1234, rand64(), rand64(), '0, MAC_W'(rand64())));
      offer_item(make_msg(CMD_UPDATE, 16'd5, 64'h5, 64'h55, 16'd1, 48'h5));
   endtask

   task automatic test_random_traffic(int n_items);
      repeat (n_items) offer_item(random_msg());
   endtask

   // receiver holds off while the sender keeps offering back to back,
   // so the output register and the work stage fill and req_tready drops
   task automatic test_output_backpressure();
      gaps_on     = 1'b0;
      hold_cycles = HOLD_OFF;
      repeat (20) offer_item(random_msg());
      gaps_on     = 1'b1;
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      rsp_tready     = 1'b0;
      parent_count   = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      gaps_on        = 1'b1;
      burst_left     = 0;
      hold_cycles    = 0;
      stall_mode     = 0;
      mode_left      = 0;
      stall_phase    = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_extreme_fields();
      test_rank_ties();
      test_duplicate_address();
      test_full_table();
      test_random_traffic(500);
      test_output_backpressure();
      test_random_traffic(560);

      req_tvalid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0 && expected_answers.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* rank_ordered_parent_table_core.f */
hdl/ropt_pkg.sv
hdl/ropt_ram.sv
hdl/ropt_datapath.sv
hdl/ropt_ctrl.sv
hdl/rank_ordered_parent_table_core.sv
dv/testbench.sv
